FILE: hw/rtl/heb_pkg.sv
// Shared types, field layout and ring map for the hit event builder.
`timescale 1ns / 1ps

package heb_pkg;

    // Field widths
    localparam int STAMP_W  = 61;
    localparam int BOARD_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int KIND_W   = 8;
    localparam int FINE_W   = 32;
    localparam int TOT_W    = 16;
    localparam int ABS_W    = 62;
    localparam int EVENT_W  = 32;
    localparam int RING_W   = 6;
    localparam int WINDOW_W = 32;

    // Input tdata layout, lowest bit up
    localparam int IN_STAMP_LO = 0;
    localparam int IN_BOARD_LO = IN_STAMP_LO + STAMP_W;
    localparam int IN_COUNT_LO = IN_BOARD_LO + BOARD_W;
    localparam int IN_CHAN_LO  = IN_COUNT_LO + COUNT_W;
    localparam int IN_KIND_LO  = IN_CHAN_LO + CHAN_W;
    localparam int IN_FINE_LO  = IN_KIND_LO + KIND_W;
    localparam int IN_TOT_LO   = IN_FINE_LO + FINE_W;
    localparam int IN_USED_W   = IN_TOT_LO + TOT_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit up
    localparam int OUT_ABS_LO   = 0;
    localparam int OUT_EVENT_LO = OUT_ABS_LO + ABS_W;
    localparam int OUT_RING_LO  = OUT_EVENT_LO + EVENT_W;
    localparam int OUT_BOARD_LO = OUT_RING_LO + RING_W;
    localparam int OUT_CHAN_LO  = OUT_BOARD_LO + BOARD_W;
    localparam int OUT_COUNT_LO = OUT_CHAN_LO + CHAN_W;
    localparam int OUT_KIND_LO  = OUT_COUNT_LO + COUNT_W;
    localparam int OUT_FINE_LO  = OUT_KIND_LO + KIND_W;
    localparam int OUT_TOT_LO   = OUT_FINE_LO + FINE_W;
    localparam int OUT_STAMP_LO = OUT_TOT_LO + TOT_W;
    localparam int OUT_USED_W   = OUT_STAMP_LO + STAMP_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // Defaults
    localparam int QUEUE_DEPTH = 4;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(200);
    localparam logic [EVENT_W-1:0]  EVENT_FIRST  = EVENT_W'(1);
    localparam logic [EVENT_W-1:0]  EVENT_MAX    = '1;
    localparam logic signed [RING_W-1:0] RING_NONE = '1;

    // Ring per board and channel group; zero marks an unmapped group
    localparam logic [4:0] RING_MAP [4][8] = '{
        '{5'd0,  5'd0,  5'd0,  5'd0,  5'd15, 5'd1,  5'd16, 5'd2},
        '{5'd17, 5'd3,  5'd18, 5'd4,  5'd19, 5'd5,  5'd20, 5'd6},
        '{5'd21, 5'd7,  5'd22, 5'd8,  5'd23, 5'd9,  5'd24, 5'd10},
        '{5'd25, 5'd11, 5'd26, 5'd12, 5'd27, 5'd13, 5'd28, 5'd14}
    };

    // Classified hit handed from front to back
    typedef struct packed {
        logic [ABS_W-1:0]          abs_time;
        logic signed [RING_W-1:0]  ring;
        logic [BOARD_W-1:0]        board;
        logic [CHAN_W-1:0]         chan;
        logic [COUNT_W-1:0]        count;
        logic [KIND_W-1:0]         kind;
        logic [FINE_W-1:0]         fine;
        logic [TOT_W-1:0]          tot;
        logic [STAMP_W-1:0]        stamp;
    } hit_item_t;

    // Map board and channel to a ring, -1 when unmapped
    function automatic logic signed [RING_W-1:0] ring_of(
        input logic [BOARD_W-1:0] board,
        input logic [CHAN_W-1:0]  chan
    );
        logic [4:0] r;
        r = RING_MAP[board[1:0]][chan[5:3]];
        if (board > BOARD_W'(3) || chan > CHAN_W'(63) || r == 5'd0)
        begin
            return RING_NONE;
        end
        return $signed({1'b0, r});
    endfunction

endpackage

FILE: hw/rtl/heb_front.sv
// Front end: accepts hits, forms absolute time and ring, feeds the queue.
`timescale 1ns / 1ps

module heb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_time, board_number, hit_count, channel_number, kind_code,
    // arrival_fine, over_threshold, zero fill
    input  logic [heb_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          push,
    output heb_pkg::hit_item_t            push_item,
    input  logic                          queue_full
);
    import heb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    hit_item_t item_reg;
    hit_item_t item_next;
    logic      accept;

    // Unpack the item and classify it
    always_comb
    begin
        item_next.stamp    = s_tdata[IN_STAMP_LO +: STAMP_W];
        item_next.board    = s_tdata[IN_BOARD_LO +: BOARD_W];
        item_next.count    = s_tdata[IN_COUNT_LO +: COUNT_W];
        item_next.chan     = s_tdata[IN_CHAN_LO +: CHAN_W];
        item_next.kind     = s_tdata[IN_KIND_LO +: KIND_W];
        item_next.fine     = s_tdata[IN_FINE_LO +: FINE_W];
        item_next.tot      = s_tdata[IN_TOT_LO +: TOT_W];
        item_next.abs_time = ABS_W'(item_next.stamp) + ABS_W'(item_next.fine);
        item_next.ring     = ring_of(item_next.board, item_next.chan);
    end

    // Hand over to the queue whenever it has room
    assign push      = valid_reg && !queue_full;
    assign push_item = item_reg;
    assign s_tready  = !valid_reg || !queue_full;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/heb_queue.sv
// Short queue that decouples the front end from the event stage.
`timescale 1ns / 1ps

module heb_queue #(
    parameter int DEPTH = heb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  heb_pkg::hit_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output heb_pkg::hit_item_t head_item
);
    import heb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    hit_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

FILE: hw/rtl/heb_back.sv
// Back end: groups hits into events and holds the result for the receiver.
`timescale 1ns / 1ps

module heb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [heb_pkg::WINDOW_W-1:0]   cfg_wdata,
    input  logic                           head_valid,
    input  heb_pkg::hit_item_t             head_item,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // abs_time, event_number, ring_number, board_out, channel_out,
    // count_out, kind_out, fine_out, tot_out, stamp_out, zero fill
    output logic [heb_pkg::OUT_DATA_W-1:0] m_tdata
);
    import heb_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic                open_reg;
    logic [ABS_W-1:0]    start_reg;
    logic [ABS_W-1:0]    start_next;
    logic [EVENT_W-1:0]  counter_reg;
    logic [EVENT_W-1:0]  counter_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    hit_item_t           out_item_reg;
    logic [EVENT_W-1:0]  out_event_reg;
    logic [ABS_W:0]      limit;
    logic                new_event;

    // Take the next item when the output register is free or drained
    assign pop = head_valid && (!out_valid_reg || m_tready);

    // Window test in one extra bit so the limit never wraps
    assign limit     = {1'b0, start_reg} + (ABS_W + 1)'(window_reg);
    assign new_event = ({1'b0, head_item.abs_time} > limit);

    always_comb
    begin
        start_next   = start_reg;
        counter_next = counter_reg;
        if (!open_reg)
        begin
            start_next   = head_item.abs_time;
            counter_next = EVENT_FIRST;
        end
        else if (new_event)
        begin
            start_next = head_item.abs_time;
            if (counter_reg != EVENT_MAX)
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            counter_reg   <= EVENT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (pop)
            begin
                open_reg    <= 1'b1;
                start_reg   <= start_next;
                counter_reg <= counter_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg  <= head_item;
            out_event_reg <= counter_next;
        end
    end

    // Pack the result item
    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_ABS_LO +: ABS_W]     = out_item_reg.abs_time;
        m_tdata[OUT_EVENT_LO +: EVENT_W] = out_event_reg;
        m_tdata[OUT_RING_LO +: RING_W]   = out_item_reg.ring;
        m_tdata[OUT_BOARD_LO +: BOARD_W] = out_item_reg.board;
        m_tdata[OUT_CHAN_LO +: CHAN_W]   = out_item_reg.chan;
        m_tdata[OUT_COUNT_LO +: COUNT_W] = out_item_reg.count;
        m_tdata[OUT_KIND_LO +: KIND_W]   = out_item_reg.kind;
        m_tdata[OUT_FINE_LO +: FINE_W]   = out_item_reg.fine;
        m_tdata[OUT_TOT_LO +: TOT_W]     = out_item_reg.tot;
        m_tdata[OUT_STAMP_LO +: STAMP_W] = out_item_reg.stamp;
    end

    assign m_tvalid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != '0)
        else $error("event counter reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (counter_reg == $past(counter_reg)
              || counter_reg == $past(counter_reg) + 1'b1
              || counter_reg == EVENT_FIRST))
        else $error("event counter jumped");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && open_reg && out_event_reg == counter_reg))
        else $error("result not loaded with current event");

endmodule

FILE: hw/rtl/hit_event_builder.sv
// Top level of the hit event builder: front end, queue and event stage.
`timescale 1ns / 1ps

// Usage:
// Hits enter on the s_ channel in time order, one per accepted item, and
// leave on the m_ channel with absolute time, ring number and event number
// added; every input item gives exactly one output item, in order.
// cfg_we / cfg_wdata load the grouping window in 0.5 ns units (200 after
// reset); write it only while no item is in flight.
// Data path: the front register (add and ring lookup) loads at the input
// accept edge, the item then passes through the queue, and the output
// register (window compare and event count) loads from the queue head
// and raises m_tvalid.
// Throughput is one item per cycle while m_tready stays high; the event
// start and count update with each pop, so items follow without gaps.
// Reset clears all valids, the queue and the event state; the next hit
// after reset opens event 1.
// When the receiver stalls, the output register holds its item and the
// queue absorbs up to QUEUE_DEPTH more plus one in the front register,
// after which s_tready drops.
module hit_event_builder #(
    parameter int QUEUE_DEPTH = heb_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [heb_pkg::WINDOW_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // block_time, board_number, hit_count, channel_number, kind_code,
    // arrival_fine, over_threshold, zero fill
    input  logic [heb_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // abs_time, event_number, ring_number, board_out, channel_out,
    // count_out, kind_out, fine_out, tot_out, stamp_out, zero fill
    output logic [heb_pkg::OUT_DATA_W-1:0] m_tdata
);
    import heb_pkg::*;

    logic      push;
    hit_item_t push_item;
    logic      queue_full;
    logic      pop;
    logic      head_valid;
    hit_item_t head_item;

    heb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    heb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    heb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
